/* design/hlm_pkg.sv */
// Shared types, codes and constants of the heartbeat liveness monitor.
// No dependencies; every other design file but hlm_ram imports this package.
package hlm_pkg;

  // Node id space and table limits
  localparam int unsigned NUM_NODES_DEF = 32;
  localparam int unsigned NODE_ID_SPAN  = 32;
  localparam int unsigned NODE_W        = 5;
  localparam int unsigned TOTAL_W       = 6;
  localparam int unsigned MISS_W        = 8;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned LIMIT_W       = 8;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [MISS_W-1:0]    MISS_SAT       = 8'd255;
  localparam logic [LIMIT_W-1:0]   MISS_LIMIT_RST = 8'd3;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd60;

  // Configuration register indexes
  typedef enum logic {
    CFG_MISS_LIMIT = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } hlm_cfg_e;

  // Request codes
  typedef enum logic [1:0] {
    REQ_HEARTBEAT = 2'd0,
    REQ_TICK      = 2'd1,
    REQ_SWEEP     = 2'd2,
    REQ_QUERY     = 2'd3
  } hlm_req_e;

  // Result event codes
  typedef enum logic [2:0] {
    EV_ACK       = 3'd0,
    EV_UNHEALTHY = 3'd1,
    EV_RECOVERED = 3'd2,
    EV_SUMMARY   = 3'd3,
    EV_QUERY     = 3'd4
  } hlm_event_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP_RD,
    ST_SWEEP_UPD,
    ST_SUMMARY
  } hlm_state_e;

  // Input item
  typedef struct packed {
    hlm_req_e          req_type;
    logic [NODE_W-1:0] node_id;
  } hlm_req_t;

  // Result item
  typedef struct packed {
    hlm_event_e         event_kind;
    logic [NODE_W-1:0]  node_ref;
    logic               node_healthy;
    logic               came_back;
    logic [TOTAL_W-1:0] healthy_total;
    logic               last;
  } hlm_res_t;

  // One table entry held in the RAM
  typedef struct packed {
    logic              healthy;
    logic [MISS_W-1:0] miss;
    logic [TIME_W-1:0] seen;
  } hlm_entry_t;

endpackage

/* design/hlm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module hlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/heartbeat_liveness_monitor_unit.sv */
// Top level of the heartbeat liveness monitor: controller, config registers,
// known bits and the entry table. Depends on hlm_pkg and hlm_ram.
//
//  Channel  | Signals                           | Handshake
//  ---------+-----------------------------------+----------------------------------
//  request  | start_i, busy_o, req_i            | taken when start_i && !busy_o
//  result   | result_valid_o, result_o          | one-cycle strobe, cannot stall
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i  | written when cfg_we_i is high
//
// Heartbeat and query read the table when accepted, then update and write back in
// ST_ACCESS; the registered result appears in the next cycle. A tick only advances
// the time counter and gives no result. A sweep reads, then updates, each of the
// min(NUM_NODES,32) table entries through the single RAM read port, then sends the summary.
// Reset clears the known bits, so no clearing pass is needed.
// Results cannot be held off; busy_o alone paces the requester.
module heartbeat_liveness_monitor_unit
  import hlm_pkg::*;
#(
  parameter int unsigned NUM_NODES = NUM_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  hlm_req_t              req_i,
  output logic                  result_valid_o,
  output hlm_res_t              result_o,
  input  logic                  cfg_we_i,
  input  hlm_cfg_e              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEPTH   = (NUM_NODES < NODE_ID_SPAN) ? NUM_NODES : NODE_ID_SPAN;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned ENTRY_W = $bits(hlm_entry_t);

  hlm_state_e           state_q, state_d;
  hlm_req_t             req_q;
  logic [TIME_W-1:0]    time_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [DEPTH-1:0]     known_q, known_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  hlm_res_t             res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic                 accept;
  logic                 id_valid;
  logic [IDX_W-1:0]     id_addr;
  logic                 id_known;
  logic                 idx_last;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_raddr;
  hlm_entry_t           ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  hlm_entry_t           rd;
  hlm_entry_t           upd;
  logic [TIME_W-1:0]    elapsed;
  logic                 timed_out;
  logic [MISS_W-1:0]    miss_inc;
  logic                 sw_known;

  hlm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign id_valid = ({1'b0, req_q.node_id} < TOTAL_W'(DEPTH));
  assign id_addr  = req_q.node_id[IDX_W-1:0];
  assign id_known = id_valid && known_q[id_addr];
  assign idx_last = (idx_q == IDX_W'(DEPTH - 1));
  assign sw_known = known_q[idx_q];
  assign rd       = hlm_entry_t'(ram_rdata);

  // Timeout check and saturating miss count of the entry just read
  assign elapsed   = time_q - rd.seen;
  assign timed_out = elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_q};
  assign miss_inc  = (rd.miss < MISS_SAT) ? rd.miss + 8'd1 : rd.miss;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            REQ_TICK:  state_d = ST_IDLE;
            REQ_SWEEP: state_d = ST_SWEEP_RD;
            default:   state_d = ST_ACCESS;
          endcase
        end
      end
      ST_ACCESS:    state_d = ST_IDLE;
      ST_SWEEP_RD:  state_d = ST_SWEEP_UPD;
      ST_SWEEP_UPD: state_d = idx_last ? ST_SUMMARY : ST_SWEEP_RD;
      ST_SUMMARY:   state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Table access, entry update and result forming
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = rd;
    ram_raddr   = idx_q;
    known_d     = known_q;
    idx_d       = idx_q;
    total_d     = total_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    upd         = rd;
    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = req_i.node_id[IDX_W-1:0];
        idx_d     = '0;
        total_d   = '0;
      end
      ST_ACCESS: begin
        res_valid_d    = 1'b1;
        res_d.node_ref = req_q.node_id;
        res_d.last     = 1'b1;
        if (req_q.req_type == REQ_HEARTBEAT) begin
          res_d.event_kind   = EV_ACK;
          res_d.node_healthy = id_valid;
          res_d.came_back    = id_valid && !(id_known && rd.healthy);
          upd.healthy        = 1'b1;
          upd.miss           = '0;
          upd.seen           = time_q;
          ram_we             = id_valid;
          ram_waddr          = id_addr;
          ram_wdata          = upd;
          if (id_valid) begin
            known_d[id_addr] = 1'b1;
          end
        end else begin
          res_d.event_kind   = EV_QUERY;
          res_d.node_healthy = id_known && rd.healthy;
        end
      end
      ST_SWEEP_RD: begin
        ram_raddr = idx_q;
      end
      ST_SWEEP_UPD: begin
        // Count a miss or recover the node, then tally its health
        if (sw_known) begin
          if (timed_out) begin
            upd.miss = miss_inc;
            if (miss_inc >= limit_q && rd.healthy) begin
              upd.healthy      = 1'b0;
              res_valid_d      = 1'b1;
              res_d.event_kind = EV_UNHEALTHY;
              res_d.node_ref   = NODE_W'(idx_q);
            end
          end else if (!rd.healthy && rd.miss != '0) begin
            upd.healthy        = 1'b1;
            upd.miss           = '0;
            res_valid_d        = 1'b1;
            res_d.event_kind   = EV_RECOVERED;
            res_d.node_ref     = NODE_W'(idx_q);
            res_d.node_healthy = 1'b1;
          end
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = upd;
          total_d   = total_q + TOTAL_W'(upd.healthy);
        end
        if (!idx_last) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_SUMMARY: begin
        res_valid_d         = 1'b1;
        res_d.event_kind    = EV_SUMMARY;
        res_d.healthy_total = total_q;
        res_d.last          = 1'b1;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  // Control registers, config and time counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      known_q     <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
      time_q      <= '0;
      limit_q     <= MISS_LIMIT_RST;
      timeout_q   <= TIMEOUT_RST;
    end else begin
      state_q     <= state_d;
      known_q     <= known_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
      if (accept && req_i.req_type == REQ_TICK) begin
        time_q <= time_q + TIME_W'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MISS_LIMIT: limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
          CFG_TIMEOUT:    timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
          default:        limit_q   <= limit_q;
        endcase
      end
    end
  end

  // Payload registers: hold the request and the outgoing item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

/* design/hlm_checker.sv */
// Port-level checker for the heartbeat liveness monitor, bound to the top.
// Depends on hlm_pkg.
module hlm_checker
  import hlm_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input hlm_req_t req_i,
  input logic     result_valid_o,
  input hlm_res_t result_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  // A tick gives no item and leaves the block free
  a_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.req_type == REQ_TICK |=> !result_valid_o && !busy_o)
    else $error("tick produced an item or raised busy");

  // Heartbeat and query stay busy for the access, then answer with one final item as the block goes idle
  a_single_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == REQ_HEARTBEAT || req_i.req_type == REQ_QUERY)
    |=> busy_o ##1 (result_valid_o && result_o.last && !busy_o))
    else $error("heartbeat or query answer missing or late");

  // A sweep occupies the block
  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.req_type == REQ_SWEEP |=> busy_o ##1 busy_o)
    else $error("sweep released busy too early");

  // Sweep events that are not final arrive while the sweep is still running
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("non-final item with the block idle");

  // The summary closes the sweep and refers to no node
  a_summary_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.event_kind == EV_SUMMARY
    |-> result_o.last && result_o.node_ref == '0 && !result_o.came_back)
    else $error("malformed sweep summary");

endmodule

bind heartbeat_liveness_monitor_unit hlm_checker u_hlm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
